FILE: rtl/bgi_pkg.sv
// Shared constants, types and command format for the bilinear grid interpolator.
// Used by every module of the block except bgi_ram; depends on nothing.
`timescale 1ns / 1ps

package bgi_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int FRAC_BITS   = 8;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 14;
    localparam int COORD_W  = 6;
    localparam int CELLS    = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(GRID_WIDTH);
    localparam int ROW_W    = $clog2(GRID_HEIGHT);
    localparam int WGT_W    = FRAC_BITS + 1;
    localparam int R_W      = SAMPLE_W + FRAC_BITS + 2;
    localparam int V_W      = R_W + FRAC_BITS + 2;
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [COL_W-1:0]           t_col;
    typedef logic [ROW_W-1:0]           t_row;
    typedef logic [FRAC_BITS-1:0]       t_frac;
    typedef logic [WGT_W-1:0]           t_wgt;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [COORD_W-1:0]         t_coord;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [R_W-1:0]      t_row_sum;
    typedef logic signed [V_W-1:0]      t_blend;

    localparam t_wgt WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic    query;
        t_addr   a00;
        t_addr   a01;
        t_addr   a10;
        t_addr   a11;
        t_sample data;
        t_frac   fx;
        t_frac   fy;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic nempty;
    } t_qstat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW1,
        S_LERP1,
        S_BLEND
    } t_state;

endpackage

FILE: rtl/bilinear_grid_interpolator_core.sv
// Bilinear grid interpolator top level: front end, command queue, back end.
// Depends on bgi_pkg, bgi_front, bgi_fifo, bgi_back.
// The block keeps a 64 x 64 grid of signed 16-bit samples in a RAM with one
// write and two read ports. A write beat (func 0) stores one sample; writes
// outside the grid are dropped. A query beat (func 1) returns one floored
// bilinear blend of the four samples around the position, with the upper
// neighbor clamped to the grid edge. The front end takes one beat per cycle
// into a 4-entry command queue while the queue has room; the back end
// retires a write from its idle state and runs a query as a sequence: two
// row reads through the two read ports, overlapped with two row lerps, then
// the column blend into the output register, which waits while that register
// holds a stalled result. A new command is taken only after the sequence ends.
// No clearing pass after reset; grid entries must be written before they are read.
`timescale 1ns / 1ps

module bilinear_grid_interpolator_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  bgi_pkg::t_coord  i_write_col,
    input  bgi_pkg::t_coord  i_write_row,
    input  bgi_pkg::t_sample i_write_height,
    input  bgi_pkg::t_pos    i_pos_x,
    input  bgi_pkg::t_pos    i_pos_y,
    output logic             o_valid,
    input  logic             i_stall,
    output bgi_pkg::t_sample o_height
);

    logic            push;
    logic            pop;
    bgi_pkg::t_cmd   cmd;
    bgi_pkg::t_cmd   head;
    bgi_pkg::t_qstat qstat;

    bgi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_write_col   (i_write_col),
        .i_write_row   (i_write_row),
        .i_write_height(i_write_height),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_q_full      (qstat.full),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    bgi_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (qstat)
    );

    bgi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_height(o_height)
    );

endmodule

FILE: rtl/bgi_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: rtl/bgi_front.sv
// Front end: takes input beats, drops out-of-grid writes, splits query positions
// into clamped neighbor addresses and fractions. Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  bgi_pkg::t_coord       i_write_col,
    input  bgi_pkg::t_coord       i_write_row,
    input  bgi_pkg::t_sample      i_write_height,
    input  bgi_pkg::t_pos         i_pos_x,
    input  bgi_pkg::t_pos         i_pos_y,
    input  logic                  i_q_full,
    output logic                  o_push,
    output bgi_pkg::t_cmd         o_cmd
);

    function automatic bgi_pkg::t_addr cell_addr(input bgi_pkg::t_row row,
                                                 input bgi_pkg::t_col col);
        cell_addr = bgi_pkg::t_addr'(row) * bgi_pkg::t_addr'(bgi_pkg::GRID_WIDTH)
                  + bgi_pkg::t_addr'(col);
    endfunction

    logic          r_vld;
    logic          n_vld;
    bgi_pkg::t_cmd r_cmd;
    bgi_pkg::t_cmd n_cmd;
    logic          accept;
    logic          keep;
    bgi_pkg::t_pos ip_x;
    bgi_pkg::t_pos ip_y;
    bgi_pkg::t_col x0;
    bgi_pkg::t_col x1;
    bgi_pkg::t_row y0;
    bgi_pkg::t_row y1;
    bgi_pkg::t_row wr_row;
    bgi_pkg::t_col wr_col;

    assign o_push  = r_vld && !i_q_full;
    assign o_stall = r_vld && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    always_comb begin
        ip_x = i_pos_x >> bgi_pkg::FRAC_BITS;
        ip_y = i_pos_y >> bgi_pkg::FRAC_BITS;
        if (32'(ip_x) >= bgi_pkg::GRID_WIDTH - 1) begin
            x0 = bgi_pkg::t_col'(bgi_pkg::GRID_WIDTH - 1);
            x1 = x0;
        end else begin
            x0 = bgi_pkg::t_col'(ip_x);
            x1 = x0 + 1'b1;
        end
        if (32'(ip_y) >= bgi_pkg::GRID_HEIGHT - 1) begin
            y0 = bgi_pkg::t_row'(bgi_pkg::GRID_HEIGHT - 1);
            y1 = y0;
        end else begin
            y0 = bgi_pkg::t_row'(ip_y);
            y1 = y0 + 1'b1;
        end
        wr_row = bgi_pkg::t_row'(i_write_row);
        wr_col = bgi_pkg::t_col'(i_write_col);

        n_cmd.query = (i_func == bgi_pkg::FUNC_QUERY);
        n_cmd.data  = i_write_height;
        n_cmd.fx    = bgi_pkg::t_frac'(i_pos_x);
        n_cmd.fy    = bgi_pkg::t_frac'(i_pos_y);
        n_cmd.a10   = cell_addr(y1, x0);
        n_cmd.a11   = cell_addr(y1, x1);
        n_cmd.a01   = cell_addr(y0, x1);
        if (i_func == bgi_pkg::FUNC_QUERY) begin
            n_cmd.a00 = cell_addr(y0, x0);
        end else begin
            n_cmd.a00 = cell_addr(wr_row, wr_col);
        end

        keep = (i_func == bgi_pkg::FUNC_QUERY)
            || (32'(i_write_col) < bgi_pkg::GRID_WIDTH
                && 32'(i_write_row) < bgi_pkg::GRID_HEIGHT);

        if (accept) begin
            n_vld = keep;
        end else begin
            n_vld = r_vld && !o_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: rtl/bgi_fifo.sv
// Short command queue between front and back ends.
// Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bgi_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output bgi_pkg::t_cmd   o_head,
    output bgi_pkg::t_qstat o_stat
);

    bgi_pkg::t_cmd                 r_mem [bgi_pkg::Q_DEPTH];
    logic [bgi_pkg::QPTR_W-1:0]    r_wptr;
    logic [bgi_pkg::QPTR_W-1:0]    r_rptr;
    logic [bgi_pkg::QPTR_W:0]      r_count;
    logic [bgi_pkg::QPTR_W:0]      n_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_stat.full   = (r_count == (bgi_pkg::QPTR_W + 1)'(bgi_pkg::Q_DEPTH));
    assign o_stat.nempty = (r_count != '0);
    assign do_push       = i_push && !o_stat.full;
    assign do_pop        = i_pop && o_stat.nempty;
    assign o_head        = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/bgi_back.sv
// Back end: executes grid writes and runs the read / lerp / blend sequence for
// queries, holding the result in the output register. Depends on bgi_pkg, bgi_ram.
`timescale 1ns / 1ps

module bgi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bgi_pkg::t_cmd    i_head,
    input  bgi_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output bgi_pkg::t_sample o_height
);

    bgi_pkg::t_state   r_state;
    bgi_pkg::t_state   n_state;
    bgi_pkg::t_addr    r_a10;
    bgi_pkg::t_addr    r_a11;
    bgi_pkg::t_frac    r_fx;
    bgi_pkg::t_frac    r_fy;
    bgi_pkg::t_row_sum r_r0;
    bgi_pkg::t_row_sum r_r1;
    bgi_pkg::t_sample  r_height;
    logic              r_out_vld;

    logic              ram_we;
    bgi_pkg::t_addr    raddr_a;
    bgi_pkg::t_addr    raddr_b;
    bgi_pkg::t_sample  rdata_a;
    bgi_pkg::t_sample  rdata_b;
    logic              start_q;
    logic              load_r0;
    logic              load_r1;
    logic              load_out;
    logic              out_free;

    bgi_pkg::t_wgt     wx0;
    bgi_pkg::t_wgt     wy0;
    bgi_pkg::t_row_sum lerp;
    bgi_pkg::t_blend   blend;

    bgi_ram #(
        .WIDTH(bgi_pkg::SAMPLE_W),
        .DEPTH(bgi_pkg::CELLS)
    ) u_grid (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (i_head.a00),
        .i_wdata  (i_head.data),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bgi_pkg::S_IDLE: begin
                if (i_qstat.nempty && i_head.query) begin
                    n_state = bgi_pkg::S_ROW1;
                end
            end
            bgi_pkg::S_ROW1:  n_state = bgi_pkg::S_LERP1;
            bgi_pkg::S_LERP1: n_state = bgi_pkg::S_BLEND;
            bgi_pkg::S_BLEND: begin
                if (out_free) begin
                    n_state = bgi_pkg::S_IDLE;
                end
            end
            default: n_state = bgi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ram_we   = 1'b0;
        o_pop    = 1'b0;
        start_q  = 1'b0;
        load_r0  = 1'b0;
        load_r1  = 1'b0;
        load_out = 1'b0;
        raddr_a  = i_head.a00;
        raddr_b  = i_head.a01;
        unique case (r_state)
            bgi_pkg::S_IDLE: begin
                o_pop   = i_qstat.nempty;
                ram_we  = i_qstat.nempty && !i_head.query;
                start_q = i_qstat.nempty && i_head.query;
            end
            bgi_pkg::S_ROW1: begin
                raddr_a = r_a10;
                raddr_b = r_a11;
                load_r0 = 1'b1;
            end
            bgi_pkg::S_LERP1: begin
                load_r1 = 1'b1;
            end
            bgi_pkg::S_BLEND: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // row lerp: (S - fx) * left + fx * right; column blend: (S - fy) * r0 + fy * r1
    always_comb begin
        wx0  = bgi_pkg::WGT_ONE - bgi_pkg::t_wgt'(r_fx);
        wy0  = bgi_pkg::WGT_ONE - bgi_pkg::t_wgt'(r_fy);
        lerp = bgi_pkg::t_row_sum'(rdata_a) * bgi_pkg::t_row_sum'($signed({1'b0, wx0}))
             + bgi_pkg::t_row_sum'(rdata_b) * bgi_pkg::t_row_sum'($signed({2'b00, r_fx}));
        blend = bgi_pkg::t_blend'(r_r0) * bgi_pkg::t_blend'($signed({1'b0, wy0}))
              + bgi_pkg::t_blend'(r_r1) * bgi_pkg::t_blend'($signed({2'b00, r_fy}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bgi_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (start_q) begin
            r_a10 <= i_head.a10;
            r_a11 <= i_head.a11;
            r_fx  <= i_head.fx;
            r_fy  <= i_head.fy;
        end
        if (load_r0) begin
            r_r0 <= lerp;
        end
        if (load_r1) begin
            r_r1 <= lerp;
        end
        if (load_out) begin
            r_height <= blend[2 * bgi_pkg::FRAC_BITS +: bgi_pkg::SAMPLE_W];
        end
    end

    assign o_valid  = r_out_vld;
    assign o_height = r_height;

`ifndef SYNTHESIS
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == bgi_pkg::S_IDLE && o_pop))
        else $error("grid write outside idle state");

    a_row1_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bgi_pkg::S_ROW1) |=> (r_state == bgi_pkg::S_LERP1))
        else $error("query sequence broken after second row read");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_out_vld && $stable(r_height)))
        else $error("result register overwritten while stalled");

    a_blend_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bgi_pkg::S_BLEND && r_out_vld && i_stall)
            |=> (r_state == bgi_pkg::S_BLEND))
        else $error("blend left before output register freed");
`endif

endmodule

FILE: test/tb_bilinear_grid_interpolator_core.sv
// Self-checking testbench for bilinear_grid_interpolator_core: writes samples, queries
// heights, and checks each result against a scoreboard that mirrors the grid and the blend.
// Depends on bgi_pkg and the bilinear_grid_interpolator_core RTL.
`timescale 1ns / 1ps

module tb_bilinear_grid_interpolator_core;
    import bgi_pkg::*;

    localparam int TOTAL_BEATS = 1750;
    localparam int TAIL_START  = 1550;
    localparam int HOLD_CYCLES = 100;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE      = 24;

    class height_board;
        t_sample grid [CELLS];
        bit      written [CELLS];
        t_sample expected_q [$];
        int      errors;

        function void corner(t_pos p, int n, output int lo, output int hi,
                             output longint frac);
            int ip;
            ip   = int'(p[POS_W-1:FRAC_BITS]);
            frac = longint'(p[FRAC_BITS-1:0]);
            if (ip >= n - 1) begin
                lo = n - 1;
                hi = n - 1;
            end else begin
                lo = ip;
                hi = ip + 1;
            end
        endfunction

        function longint sample(int c, int r);
            return longint'(grid[r * GRID_WIDTH + c]);
        endfunction

        function t_sample blend_at(t_pos px, t_pos py);
            int     x0, x1, y0, y1;
            longint fx, fy, r0, r1, v, unit;
            unit = longint'(1) << FRAC_BITS;
            corner(px, GRID_WIDTH, x0, x1, fx);
            corner(py, GRID_HEIGHT, y0, y1, fy);
            r0 = (unit - fx) * sample(x0, y0) + fx * sample(x1, y0);
            r1 = (unit - fx) * sample(x0, y1) + fx * sample(x1, y1);
            v  = (unit - fy) * r0 + fy * r1;
            v  = v >>> (2 * FRAC_BITS);
            return t_sample'(v);
        endfunction

        function void note_beat(logic f, t_coord c, t_coord r, t_sample h,
                                t_pos px, t_pos py);
            if (f == FUNC_WRITE) begin
                if (c < GRID_WIDTH && r < GRID_HEIGHT) begin
                    grid[r * GRID_WIDTH + c]    = h;
                    written[r * GRID_WIDTH + c] = 1'b1;
                end
            end else begin
                expected_q.push_back(blend_at(px, py));
            end
        endfunction

        function void check_height(t_sample got);
            t_sample want;
            if (expected_q.size() == 0) begin
                $display("%0t ERROR unexpected height: expected none, actual %0d", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    $display("%0t ERROR height: expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    logic    i_func;
    t_coord  i_write_col;
    t_coord  i_write_row;
    t_sample i_write_height;
    t_pos    i_pos_x;
    t_pos    i_pos_y;
    logic    o_valid;
    logic    i_stall;
    t_sample o_height;

    height_board board = new;
    int beats_sent  = 0;
    int tx_gap_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req    = 1'b0;
    int idle_cycles = 0;

    bilinear_grid_interpolator_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_write_col    (i_write_col),
        .i_write_row    (i_write_row),
        .i_write_height (i_write_height),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_height       (o_height)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_pos rand_pos();
        t_pos p;
        p = t_pos'($urandom_range(0, 16383));
        case ($urandom_range(0, 7))
            0: p[FRAC_BITS-1:0] = '0;
            1: p[FRAC_BITS-1:0] = '1;
            2: p[POS_W-1:FRAC_BITS] = '1;
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_sample rand_height();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_beat(logic f, t_coord c, t_coord r, t_sample h, t_pos px, t_pos py);
        i_valid        <= 1'b1;
        i_func         <= f;
        i_write_col    <= c;
        i_write_row    <= r;
        i_write_height <= h;
        i_pos_x        <= px;
        i_pos_y        <= py;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.note_beat(f, c, r, h, px, py);
        beats_sent++;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task automatic put_sample(t_coord c, t_coord r, t_sample h);
        send_beat(FUNC_WRITE, c, r, h, rand_pos(), rand_pos());
    endtask

    task automatic cover_cell(int c, int r);
        if (!board.written[r * GRID_WIDTH + c])
            put_sample(t_coord'(c), t_coord'(r), rand_height());
    endtask

    // Makes sure all four neighbors hold data before the query goes out.
    task automatic ask_height(t_pos px, t_pos py);
        int     x0, x1, y0, y1;
        longint fx, fy;
        board.corner(px, GRID_WIDTH, x0, x1, fx);
        board.corner(py, GRID_HEIGHT, y0, y1, fy);
        cover_cell(x0, y0);
        cover_cell(x1, y0);
        cover_cell(x0, y1);
        cover_cell(x1, y1);
        send_beat(FUNC_QUERY, t_coord'($urandom_range(0, 63)), t_coord'($urandom_range(0, 63)),
                  rand_height(), px, py);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            board.check_height(o_height);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int     pick;
        int     x0, x1, y0, y1;
        int     phase_mark;
        bit     did_hold;
        bit     did_drain;
        longint fx, fy;
        t_pos   px, py;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = FUNC_WRITE;
        i_write_col    = '0;
        i_write_row    = '0;
        i_write_height = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        phase_mark     = 0;
        did_hold       = 1'b0;
        did_drain      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extreme samples, integer and full fractions, edge clamping
        put_sample(6'd0, 6'd0, 16'sh7FFF);
        put_sample(6'd1, 6'd0, 16'sh8000);
        put_sample(6'd0, 6'd1, 16'sh8000);
        put_sample(6'd1, 6'd1, 16'sh7FFF);
        ask_height(14'h0000, 14'h0000);
        ask_height(14'h0080, 14'h0080);
        ask_height(14'h00FF, 14'h00FF);
        ask_height(14'h00FF, 14'h0000);
        ask_height(14'h0000, 14'h00FF);
        put_sample(6'd63, 6'd63, 16'sh8000);
        put_sample(6'd62, 6'd63, 16'sh7FFF);
        put_sample(6'd63, 6'd62, 16'sh7FFF);
        put_sample(6'd62, 6'd62, 16'sh8000);
        ask_height(14'h3FFF, 14'h3FFF);
        ask_height({6'd63, 8'h00}, {6'd62, 8'h80});
        ask_height({6'd62, 8'hFF}, {6'd63, 8'h01});
        ask_height({6'd62, 8'h80}, {6'd62, 8'h80});
        put_sample(6'd63, 6'd0, 16'shFFFF);
        put_sample(6'd62, 6'd0, 16'sh0001);
        ask_height({6'd63, 8'hFF}, {6'd0, 8'h40});

        while (beats_sent < TOTAL_BEATS) begin
            if (beats_sent >= TAIL_START) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else if (beats_sent >= phase_mark) begin
                phase_mark += 150;
                case ($urandom_range(0, 2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 10;
                    default: tx_gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 10;
                    default: rx_stall_pct = 35;
                endcase
            end

            if (!did_hold && beats_sent > 600) begin
                did_hold   = 1'b1;
                tx_gap_pct = 0;
                hold_req   = 1'b1;
                repeat (40) ask_height(rand_pos(), rand_pos());
            end
            if (!did_drain && beats_sent > 1100) begin
                did_drain = 1'b1;
                wait_drained();
            end

            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                put_sample(t_coord'($urandom_range(0, 63)), t_coord'($urandom_range(0, 63)),
                           rand_height());
            end else if (pick < 80) begin
                ask_height(rand_pos(), rand_pos());
            end else begin
                // fresh neighborhood, then a few queries inside that cell
                px = rand_pos();
                py = rand_pos();
                board.corner(px, GRID_WIDTH, x0, x1, fx);
                board.corner(py, GRID_HEIGHT, y0, y1, fy);
                put_sample(t_coord'(x0), t_coord'(y0), rand_height());
                put_sample(t_coord'(x1), t_coord'(y0), rand_height());
                put_sample(t_coord'(x0), t_coord'(y1), rand_height());
                put_sample(t_coord'(x1), t_coord'(y1), rand_height());
                repeat ($urandom_range(1, 3))
                    ask_height({px[POS_W-1:FRAC_BITS], t_frac'($urandom_range(0, 255))},
                               {py[POS_W-1:FRAC_BITS], t_frac'($urandom_range(0, 255))});
            end
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);

        if (board.expected_q.size() != 0) begin
            $display("%0t ERROR %0d heights never arrived", $time, board.expected_q.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
